// ===== src/dmrp_pkg.sv =====
`default_nettype none

package dmrp_pkg;

   // Full-scale power value; duty = power * period / POWER_SCALE.
   localparam int POWER_SCALE = 100;
   // Highest ramp level a start item may ask for.
   localparam logic [6:0] LEVEL_MAX = 7'd100;

   // Power and product widths (power never exceeds 255).
   localparam int PWR_W       = 8;
   localparam int PROD_W      = 2 * PWR_W;
   localparam int RECIP_SHIFT = PROD_W;
   localparam int EST_W       = 2 * PROD_W;
   localparam int QP_W        = PROD_W + PWR_W;

   // Reciprocal of POWER_SCALE, rounded down, scaled by 2**RECIP_SHIFT.
   localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** RECIP_SHIFT) / POWER_SCALE);
   localparam logic [PWR_W-1:0]  SCALE_P = PWR_W'(POWER_SCALE);
   localparam logic [PROD_W-1:0] SCALE_W = PROD_W'(POWER_SCALE);

   // Action codes.
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   // Maneuver codes.
   localparam logic [1:0] MODE_UP_ONLY = 2'd0;
   localparam logic [1:0] MODE_PULSE   = 2'd1;
   localparam logic [1:0] MODE_DOWN    = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COMP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COMP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TICKS = 3'd4;
   localparam int CSR_DATA_W = 8;

   // Sequencer phases.
   typedef enum logic [4:0] {
      PH_IDLE     = 5'b00001,
      PH_UP_ONLY  = 5'b00010,
      PH_UP_PULSE = 5'b00100,
      PH_HOLD     = 5'b01000,
      PH_DOWN     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        action;
      logic [1:0]  mode;
      logic        left_forward;
      logic        right_forward;
      logic [6:0]  target_level;
      logic [15:0] hold_ticks;
   } req_item_type;

   typedef struct packed {
      logic [7:0] left_pos_duty;
      logic [7:0] left_neg_duty;
      logic [7:0] right_pos_duty;
      logic [7:0] right_neg_duty;
      logic       busy_res;
      logic [6:0] current_level;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== src/dmrp_if.sv =====
`default_nettype none

// Input item channel.
interface dmrp_req_if;
   logic                       valid;
   logic                       ready;
   dmrp_pkg::req_item_type     payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// Result item channel.
interface dmrp_rsp_if;
   logic                       valid;
   logic                       ready;
   dmrp_pkg::rsp_item_type     payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/dual_motor_ramp_pwm_sequencer_core.sv =====
`default_nettype none

// Channel   Dir   Handshake         Content
// req_bus   in    valid/ready       tick or start item
// rsp_bus   out   valid/ready       four duties, busy flag, ramp level
// csr_*     in    csr_wr_en only    pwm_period, brake_mode, comps, ramp_ticks
//
// One item is accepted per cycle unless a stalled result holds the stages.
// The four stages are sequencing, power times period, reciprocal multiply
// and remainder correction with side selection.
// Reset is synchronous and returns the sequencer and registers to defaults.
// A stalled result backs up the stages; up to four items are held in flight.

module dual_motor_ramp_pwm_sequencer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   dmrp_req_if.sink                                 req_bus,
   dmrp_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_wr_en,
   input  wire logic [dmrp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dmrp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   typedef struct packed {
      logic       apply;
      logic [6:0] level;
      logic       busy;
      logic       left_dir;
      logic       right_dir;
   } s1_type;

   typedef struct packed {
      s1_type                        base;
      logic [dmrp_pkg::PROD_W-1:0]   left_prod;
      logic [dmrp_pkg::PROD_W-1:0]   right_prod;
   } s2_type;

   typedef struct packed {
      s2_type                        mid;
      logic [dmrp_pkg::PROD_W-1:0]   left_q;
      logic [dmrp_pkg::PROD_W-1:0]   right_q;
   } s3_type;

   // Configuration registers.
   logic [7:0] pwm_period_ff;
   logic       brake_mode_ff;
   logic [6:0] left_comp_ff;
   logic [6:0] right_comp_ff;
   logic [7:0] ramp_ticks_ff;

   // Sequencer state.
   dmrp_pkg::phase_type phase_ff, phase_in;
   logic [6:0]  level_ff, level_in;
   logic [6:0]  peak_ff, peak_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] hold_ff, hold_in;
   logic        left_dir_ff, left_dir_in;
   logic        right_dir_ff, right_dir_in;
   logic [31:0] duty_hold_ff, duty_hold_in;

   // Stage registers.
   logic   p1_valid_ff, p2_valid_ff, p3_valid_ff, rsp_valid_ff;
   s1_type p1_ff, p1_in;
   s2_type p2_ff, p2_in;
   s3_type p3_ff, p3_in;
   dmrp_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic adv_out, rdy3, rdy2, rdy1, req_acc, hold_write;
   logic apply;
   logic [15:0] tick_next;
   logic [7:0]  dwell;
   logic [6:0]  tgt_sat;

   dmrp_pkg::req_item_type req;

   // Stall chain: a stage takes a new item when it is empty or moves on.
   always_comb begin
      adv_out = !rsp_valid_ff || rsp_bus.ready;
      rdy3    = !p3_valid_ff || adv_out;
      rdy2    = !p2_valid_ff || rdy3;
      rdy1    = !p1_valid_ff || rdy2;
      req_acc = req_bus.valid && rdy1;
   end

   assign req_bus.ready   = rdy1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_item_ff;
   assign req             = req_bus.payload;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= 8'd199;
         brake_mode_ff <= 1'b0;
         left_comp_ff  <= 7'd0;
         right_comp_ff <= 7'd0;
         ramp_ticks_ff <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            dmrp_pkg::CSR_PWM_PERIOD: pwm_period_ff <= csr_wr_data;
            dmrp_pkg::CSR_BRAKE_MODE: brake_mode_ff <= csr_wr_data[0];
            dmrp_pkg::CSR_LEFT_COMP:  left_comp_ff  <= csr_wr_data[6:0];
            dmrp_pkg::CSR_RIGHT_COMP: right_comp_ff <= csr_wr_data[6:0];
            dmrp_pkg::CSR_RAMP_TICKS: ramp_ticks_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequencer: next phase, level and counters for the accepted item.
   always_comb begin
      phase_in     = phase_ff;
      level_in     = level_ff;
      peak_in      = peak_ff;
      tick_in      = tick_ff;
      hold_in      = hold_ff;
      left_dir_in  = left_dir_ff;
      right_dir_in = right_dir_ff;
      apply        = 1'b0;
      tick_next    = tick_ff + 16'd1;
      dwell        = (ramp_ticks_ff == 8'd0) ? 8'd1 : ramp_ticks_ff;
      tgt_sat      = (req.target_level > dmrp_pkg::LEVEL_MAX) ?
                     dmrp_pkg::LEVEL_MAX : req.target_level;
      if (req_acc) begin
         if (req.action == dmrp_pkg::ACTION_START) begin
            if (req.mode inside {dmrp_pkg::MODE_UP_ONLY, dmrp_pkg::MODE_PULSE,
                                 dmrp_pkg::MODE_DOWN}) begin
               left_dir_in  = req.left_forward;
               right_dir_in = req.right_forward;
               peak_in      = tgt_sat;
               hold_in      = req.hold_ticks;
               tick_in      = 16'd0;
               if (req.mode == dmrp_pkg::MODE_DOWN) begin
                  phase_in = dmrp_pkg::PH_DOWN;
                  apply    = 1'b1;
               end else if (tgt_sat == 7'd0) begin
                  if (req.mode == dmrp_pkg::MODE_UP_ONLY) begin
                     phase_in = dmrp_pkg::PH_IDLE;
                  end else if (req.hold_ticks == 16'd0) begin
                     // Pulse with no peak and no hold goes straight to ramp down.
                     phase_in = dmrp_pkg::PH_DOWN;
                     level_in = 7'd0;
                     apply    = 1'b1;
                  end else begin
                     phase_in = dmrp_pkg::PH_HOLD;
                  end
               end else begin
                  phase_in = (req.mode == dmrp_pkg::MODE_UP_ONLY) ?
                             dmrp_pkg::PH_UP_ONLY : dmrp_pkg::PH_UP_PULSE;
                  level_in = 7'd1;
                  apply    = 1'b1;
               end
            end
         end else begin
            case (phase_ff)
               dmrp_pkg::PH_IDLE: ;
               dmrp_pkg::PH_HOLD: begin
                  if (tick_next >= hold_ff) begin
                     phase_in = dmrp_pkg::PH_DOWN;
                     level_in = peak_ff;
                     tick_in  = 16'd0;
                     apply    = 1'b1;
                  end else begin
                     tick_in = tick_next;
                  end
               end
               dmrp_pkg::PH_DOWN: begin
                  if (tick_next < {8'd0, dwell}) begin
                     tick_in = tick_next;
                  end else begin
                     tick_in = 16'd0;
                     if (level_ff == 7'd0) begin
                        phase_in = dmrp_pkg::PH_IDLE;
                     end else begin
                        level_in = level_ff - 7'd1;
                        apply    = 1'b1;
                     end
                  end
               end
               dmrp_pkg::PH_UP_ONLY, dmrp_pkg::PH_UP_PULSE: begin
                  if (tick_next < {8'd0, dwell}) begin
                     tick_in = tick_next;
                  end else begin
                     tick_in = 16'd0;
                     if (level_ff < peak_ff) begin
                        level_in = level_ff + 7'd1;
                        apply    = 1'b1;
                     end else if (phase_ff == dmrp_pkg::PH_UP_PULSE) begin
                        if (hold_ff == 16'd0) begin
                           phase_in = dmrp_pkg::PH_DOWN;
                           level_in = peak_ff;
                           apply    = 1'b1;
                        end else begin
                           phase_in = dmrp_pkg::PH_HOLD;
                        end
                     end else begin
                        phase_in = dmrp_pkg::PH_IDLE;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      p1_in.apply     = apply;
      p1_in.level     = level_in;
      p1_in.busy      = (phase_in != dmrp_pkg::PH_IDLE);
      p1_in.left_dir  = left_dir_in;
      p1_in.right_dir = right_dir_in;
   end

   // Stage two: saturated power times the period.
   always_comb begin
      logic [dmrp_pkg::PWR_W-1:0] lsum, rsum, lpow, rpow;
      lsum = {1'b0, p1_ff.level} + {1'b0, left_comp_ff};
      rsum = {1'b0, p1_ff.level} + {1'b0, right_comp_ff};
      lpow = (lsum > dmrp_pkg::SCALE_P) ? dmrp_pkg::SCALE_P : lsum;
      rpow = (rsum > dmrp_pkg::SCALE_P) ? dmrp_pkg::SCALE_P : rsum;
      p2_in.base       = p1_ff;
      p2_in.left_prod  = dmrp_pkg::PROD_W'(lpow) * dmrp_pkg::PROD_W'(pwm_period_ff);
      p2_in.right_prod = dmrp_pkg::PROD_W'(rpow) * dmrp_pkg::PROD_W'(pwm_period_ff);
   end

   // Stage three: quotient estimate by the scaled reciprocal.
   always_comb begin
      logic [dmrp_pkg::EST_W-1:0] lest, rest;
      lest = dmrp_pkg::EST_W'(p2_ff.left_prod) * dmrp_pkg::EST_W'(dmrp_pkg::RECIP);
      rest = dmrp_pkg::EST_W'(p2_ff.right_prod) * dmrp_pkg::EST_W'(dmrp_pkg::RECIP);
      p3_in.mid     = p2_ff;
      p3_in.left_q  = lest[dmrp_pkg::EST_W-1:dmrp_pkg::RECIP_SHIFT];
      p3_in.right_q = rest[dmrp_pkg::EST_W-1:dmrp_pkg::RECIP_SHIFT];
   end

   // Stage four: correct the estimate by one, then place the duties.
   always_comb begin
      logic [dmrp_pkg::QP_W-1:0]   lqp, rqp;
      logic [dmrp_pkg::PROD_W-1:0] lrem, rrem, lq, rq;
      logic [7:0] lduty, rduty, lpos, lneg, rpos, rneg;
      lqp  = dmrp_pkg::QP_W'(p3_ff.left_q) * dmrp_pkg::QP_W'(dmrp_pkg::SCALE_P);
      rqp  = dmrp_pkg::QP_W'(p3_ff.right_q) * dmrp_pkg::QP_W'(dmrp_pkg::SCALE_P);
      lrem = p3_ff.mid.left_prod - lqp[dmrp_pkg::PROD_W-1:0];
      rrem = p3_ff.mid.right_prod - rqp[dmrp_pkg::PROD_W-1:0];
      lq   = (lrem >= dmrp_pkg::SCALE_W) ?
             p3_ff.left_q + dmrp_pkg::PROD_W'(1) : p3_ff.left_q;
      rq   = (rrem >= dmrp_pkg::SCALE_W) ?
             p3_ff.right_q + dmrp_pkg::PROD_W'(1) : p3_ff.right_q;
      lduty = (lq > dmrp_pkg::PROD_W'(255)) ? 8'd255 : lq[7:0];
      rduty = (rq > dmrp_pkg::PROD_W'(255)) ? 8'd255 : rq[7:0];
      // Brake mode inverts the duty and holds the other side at the period.
      lpos = brake_mode_ff ? pwm_period_ff - lduty : 8'd0;
      lneg = brake_mode_ff ? pwm_period_ff : lduty;
      rpos = brake_mode_ff ? pwm_period_ff - rduty : 8'd0;
      rneg = brake_mode_ff ? pwm_period_ff : rduty;
      // Reverse direction swaps the two sides of a motor.
      if (p3_ff.mid.base.left_dir) begin
         duty_hold_in[7:0]  = lpos;
         duty_hold_in[15:8] = lneg;
      end else begin
         duty_hold_in[7:0]  = lneg;
         duty_hold_in[15:8] = lpos;
      end
      if (p3_ff.mid.base.right_dir) begin
         duty_hold_in[23:16] = rpos;
         duty_hold_in[31:24] = rneg;
      end else begin
         duty_hold_in[23:16] = rneg;
         duty_hold_in[31:24] = rpos;
      end
      hold_write = p3_valid_ff && adv_out && p3_ff.mid.base.apply;
      if (p3_ff.mid.base.apply) begin
         rsp_item_in.left_pos_duty  = duty_hold_in[7:0];
         rsp_item_in.left_neg_duty  = duty_hold_in[15:8];
         rsp_item_in.right_pos_duty = duty_hold_in[23:16];
         rsp_item_in.right_neg_duty = duty_hold_in[31:24];
      end else begin
         rsp_item_in.left_pos_duty  = duty_hold_ff[7:0];
         rsp_item_in.left_neg_duty  = duty_hold_ff[15:8];
         rsp_item_in.right_pos_duty = duty_hold_ff[23:16];
         rsp_item_in.right_neg_duty = duty_hold_ff[31:24];
      end
      rsp_item_in.busy_res      = p3_ff.mid.base.busy;
      rsp_item_in.current_level = p3_ff.mid.base.level;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dmrp_pkg::PH_IDLE;
         level_ff     <= 7'd0;
         peak_ff      <= 7'd0;
         tick_ff      <= 16'd0;
         hold_ff      <= 16'd0;
         left_dir_ff  <= 1'b1;
         right_dir_ff <= 1'b1;
         duty_hold_ff <= 32'd0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         peak_ff      <= peak_in;
         tick_ff      <= tick_in;
         hold_ff      <= hold_in;
         left_dir_ff  <= left_dir_in;
         right_dir_ff <= right_dir_in;
         if (hold_write) begin
            duty_hold_ff <= duty_hold_in;
         end
         if (rdy1) begin
            p1_valid_ff <= req_acc;
         end
         if (rdy2) begin
            p2_valid_ff <= p1_valid_ff;
         end
         if (rdy3) begin
            p3_valid_ff <= p2_valid_ff;
         end
         if (adv_out) begin
            rsp_valid_ff <= p3_valid_ff;
         end
      end
   end

   // Stage payloads move with their valid bits.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_ff <= p1_in;
      end
      if (rdy2) begin
         p2_ff <= p2_in;
      end
      if (rdy3) begin
         p3_ff <= p3_in;
      end
      if (adv_out && p3_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // The held duties change only when an applying item leaves the last stage.
   a_duty_hold_stable: assert property (@(posedge clock) disable iff (reset)
      !hold_write |=> $stable(duty_hold_ff))
      else $error("held duties changed without a level change");

   // An idle sequencer keeps its tick count cleared.
   a_idle_tick_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dmrp_pkg::PH_IDLE) |-> (tick_ff == 16'd0))
      else $error("tick count not cleared while idle");

   // While ramping up the level lies between one and the peak.
   a_up_level_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dmrp_pkg::PH_UP_ONLY || phase_ff == dmrp_pkg::PH_UP_PULSE) |->
      (level_ff != 7'd0 && level_ff <= peak_ff))
      else $error("ramp level outside one to peak");

   // The level never passes the saturation limit.
   a_level_max: assert property (@(posedge clock) disable iff (reset)
      level_ff <= dmrp_pkg::LEVEL_MAX)
      else $error("ramp level above limit");

   // An accepted item enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> p1_valid_ff)
      else $error("accepted item lost at the first stage");

endmodule

`default_nettype wire

// ===== tb/sv/dual_motor_ramp_pwm_sequencer_core_tb.sv =====
import dmrp_pkg::*;

// Predicts the duties, busy flag and ramp level for every accepted item and
// compares them, in order, with the results that come back from the block.
class ramp_duty_scoreboard;
   // Register copies.
   logic [7:0]  period;
   logic        brake;
   logic [6:0]  left_comp;
   logic [6:0]  right_comp;
   logic [7:0]  ramp_ticks;

   // Sequencer copy.
   phase_type   phase;
   logic [6:0]  level;
   logic [6:0]  peak;
   logic [15:0] tick_count;
   logic [15:0] hold_length;
   logic        left_fwd;
   logic        right_fwd;
   logic [7:0]  left_pos;
   logic [7:0]  left_neg;
   logic [7:0]  right_pos;
   logic [7:0]  right_neg;

   rsp_item_type expected_q[$];
   int errors;
   int checked;

   function new();
      period      = 8'd199;
      brake       = 1'b0;
      left_comp   = '0;
      right_comp  = '0;
      ramp_ticks  = 8'd1;
      phase       = PH_IDLE;
      level       = '0;
      peak        = '0;
      tick_count  = '0;
      hold_length = '0;
      left_fwd    = 1'b1;
      right_fwd   = 1'b1;
      left_pos    = '0;
      left_neg    = '0;
      right_pos   = '0;
      right_neg   = '0;
      errors      = 0;
      checked     = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_PWM_PERIOD: period     = data;
         CSR_BRAKE_MODE: brake      = data[0];
         CSR_LEFT_COMP:  left_comp  = data[6:0];
         CSR_RIGHT_COMP: right_comp = data[6:0];
         CSR_RAMP_TICKS: ramp_ticks = data;
         default: ;
      endcase
   endfunction

   // Returns {pos, neg} for one motor at the present level.
   function logic [15:0] side_duties(logic [6:0] comp, logic fwd);
      int unsigned power;
      int unsigned duty;
      logic [7:0] pos;
      logic [7:0] neg;
      power = 32'(level) + 32'(comp);
      if (power > POWER_SCALE) begin
         power = POWER_SCALE;
      end
      duty = (power * 32'(period)) / POWER_SCALE;
      if (brake) begin
         pos = period - 8'(duty);
         neg = period;
      end else begin
         pos = 8'd0;
         neg = 8'(duty);
      end
      return fwd ? {pos, neg} : {neg, pos};
   endfunction

   function void apply_level();
      {left_pos, left_neg}   = side_duties(left_comp, left_fwd);
      {right_pos, right_neg} = side_duties(right_comp, right_fwd);
      tick_count = '0;
   endfunction

   function void enter_down(logic [6:0] from_level);
      phase = PH_DOWN;
      level = from_level;
      apply_level();
   endfunction

   function void enter_hold();
      tick_count = '0;
      if (hold_length == 16'd0) begin
         enter_down(peak);
      end else begin
         phase = PH_HOLD;
      end
   endfunction

   function void advance_tick();
      logic [15:0] dwell;
      if (phase == PH_IDLE) begin
         return;
      end
      tick_count = tick_count + 16'd1;
      if (phase == PH_HOLD) begin
         if (tick_count >= hold_length) begin
            enter_down(peak);
         end
         return;
      end
      dwell = (ramp_ticks == 8'd0) ? 16'd1 : {8'd0, ramp_ticks};
      if (tick_count < dwell) begin
         return;
      end
      if (phase == PH_DOWN) begin
         if (level == 7'd0) begin
            phase = PH_IDLE;
            tick_count = '0;
         end else begin
            level = level - 7'd1;
            apply_level();
         end
      end else if (level < peak) begin
         level = level + 7'd1;
         apply_level();
      end else if (phase == PH_UP_PULSE) begin
         enter_hold();
      end else begin
         phase = PH_IDLE;
         tick_count = '0;
      end
   endfunction

   function void start_maneuver(req_item_type it);
      logic [6:0] target;
      if (it.mode != MODE_UP_ONLY && it.mode != MODE_PULSE && it.mode != MODE_DOWN) begin
         return;
      end
      target      = (it.target_level > LEVEL_MAX) ? LEVEL_MAX : it.target_level;
      left_fwd    = it.left_forward;
      right_fwd   = it.right_forward;
      peak        = target;
      hold_length = it.hold_ticks;
      tick_count  = '0;
      if (it.mode == MODE_DOWN) begin
         enter_down(level);
      end else if (target == 7'd0) begin
         if (it.mode == MODE_UP_ONLY) begin
            phase = PH_IDLE;
         end else begin
            enter_hold();
         end
      end else begin
         phase = (it.mode == MODE_UP_ONLY) ? PH_UP_ONLY : PH_UP_PULSE;
         level = 7'd1;
         apply_level();
      end
   endfunction

   // An accepted item advances the sequencer and queues the result it causes.
   function void note_request(req_item_type it);
      rsp_item_type exp;
      if (it.action == ACTION_START) begin
         start_maneuver(it);
      end else begin
         advance_tick();
      end
      exp.left_pos_duty  = left_pos;
      exp.left_neg_duty  = left_neg;
      exp.right_pos_duty = right_pos;
      exp.right_neg_duty = right_neg;
      exp.busy_res       = (phase != PH_IDLE);
      exp.current_level  = level;
      expected_q.push_back(exp);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 100) begin
         $display("MISMATCH at result %0d, %s: got %0d, expected %0d", checked, what, got,
                  want);
      end
   endtask

   task check_response(rsp_item_type got);
      rsp_item_type exp;
      if (expected_q.size() == 0) begin
         report_mismatch("result with no item waiting", 16'd0, 16'd0);
         return;
      end
      exp = expected_q.pop_front();
      if (got.left_pos_duty !== exp.left_pos_duty) begin
         report_mismatch("left_pos_duty", 16'(got.left_pos_duty), 16'(exp.left_pos_duty));
      end
      if (got.left_neg_duty !== exp.left_neg_duty) begin
         report_mismatch("left_neg_duty", 16'(got.left_neg_duty), 16'(exp.left_neg_duty));
      end
      if (got.right_pos_duty !== exp.right_pos_duty) begin
         report_mismatch("right_pos_duty", 16'(got.right_pos_duty),
                         16'(exp.right_pos_duty));
      end
      if (got.right_neg_duty !== exp.right_neg_duty) begin
         report_mismatch("right_neg_duty", 16'(got.right_neg_duty),
                         16'(exp.right_neg_duty));
      end
      if (got.busy_res !== exp.busy_res) begin
         report_mismatch("busy_res", 16'(got.busy_res), 16'(exp.busy_res));
      end
      if (got.current_level !== exp.current_level) begin
         report_mismatch("current_level", 16'(got.current_level), 16'(exp.current_level));
      end
      checked++;
   endtask
endclass

module dual_motor_ramp_pwm_sequencer_core_tb;

   // The fourth mode code, which the block ignores.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_CYCLES  = 150;
   localparam int STALL_AFTER   = 400;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 125;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   dmrp_req_if req_if();
   dmrp_rsp_if rsp_if();

   ramp_duty_scoreboard sb = new();

   bit steady;
   int items_sent;
   int settings_used;
   int idle_cycles;

   dual_motor_ramp_pwm_sequencer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Builders for input items; unused fields of a tick carry random bits.
   function automatic req_item_type make_tick();
      req_item_type it;
      it = $bits(req_item_type)'($urandom);
      it.action = ACTION_TICK;
      return it;
   endfunction

   function automatic req_item_type make_start(logic [1:0] mode, logic lf, logic rf,
                                               logic [6:0] target, logic [15:0] hold);
      req_item_type it;
      it.action        = ACTION_START;
      it.mode          = mode;
      it.left_forward  = lf;
      it.right_forward = rf;
      it.target_level  = target;
      it.hold_ticks    = hold;
      return it;
   endfunction

   // Mostly short maneuvers, with a few large targets and long holds.
   function automatic req_item_type random_start();
      int pick;
      logic [1:0] mode;
      logic [6:0] target;
      logic [15:0] hold;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         mode = MODE_UNUSED;
      end else if (pick < 35) begin
         mode = MODE_UP_ONLY;
      end else if (pick < 75) begin
         mode = MODE_PULSE;
      end else begin
         mode = MODE_DOWN;
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         target = 7'($urandom_range(0, 8));
      end else if (pick == 8) begin
         target = 7'($urandom_range(90, 127));
      end else begin
         target = 7'($urandom_range(0, 127));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         hold = 16'($urandom_range(0, 4));
      end else if (pick < 9) begin
         hold = 16'($urandom_range(5, 40));
      end else begin
         hold = 16'($urandom_range(0, 65535));
      end
      return make_start(mode, 1'($urandom), 1'($urandom), target, hold);
   endfunction

   // Offers one item after a random gap and returns at the edge that accepts it.
   task automatic send_item(req_item_type it);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(it);
      items_sent++;
   endtask

   // Writes all five registers on consecutive edges; callers drain results first.
   task automatic program_registers(logic [7:0] period, logic brake, logic [6:0] lcomp,
                                    logic [6:0] rcomp, logic [7:0] rticks);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0] val [5];
      idx = '{CSR_PWM_PERIOD, CSR_BRAKE_MODE, CSR_LEFT_COMP, CSR_RIGHT_COMP, CSR_RAMP_TICKS};
      val = '{period, {7'($urandom), brake}, {1'($urandom), lcomp}, {1'($urandom), rcomp},
              rticks};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= val[i];
         sb.write_register(idx[i], val[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Waits for every expected result, then lets the pipeline settle.
   task automatic drain_results();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random items: starts are likely while idle, rare while a maneuver runs.
   task automatic run_random(int count);
      int pick;
      req_item_type it;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            it = $bits(req_item_type)'($urandom);
         end else if (sb.phase == PH_IDLE ? pick < 60 : pick < 11) begin
            it = random_start();
         end else begin
            it = make_tick();
         end
         send_item(it);
      end
      req_if.valid <= 1'b0;
   endtask

   // Result side: random ready gaps and one long hold-off to back up the pipeline.
   initial begin
      int gap;
      bit held_off;
      held_off = 1'b0;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 7);
         if (!held_off && sb.checked >= STALL_AFTER) begin
            gap = STALL_CYCLES;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         sb.check_response(rsp_if.payload);
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   initial begin
      idle_cycles = 0;
      wait (!reset);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Watchdog expired after %0d cycles without a handshake", IDLE_LIMIT);
      $display("dual_motor_ramp_pwm_sequencer_core test failed");
      $finish;
   end

   // Main sequence.
   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      steady         = 1'b0;
      items_sent     = 0;
      settings_used  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset register values.
      send_item(make_tick());
      // Up only with a zero target latches the directions and stays idle.
      send_item(make_start(MODE_UP_ONLY, 1'b0, 1'b0, 7'd0, 16'd5));
      send_item(make_start(MODE_UP_ONLY, 1'b0, 1'b1, 7'd3, 16'd0));
      repeat (3) send_item(make_tick());
      // Pulse with no hold ramps up and then goes straight into the ramp down.
      send_item(make_start(MODE_PULSE, 1'b1, 1'b0, 7'd2, 16'd0));
      repeat (4) send_item(make_tick());
      // Pulse with a zero target holds in place, then ramps down from zero.
      send_item(make_start(MODE_PULSE, 1'b1, 1'b1, 7'd0, 16'd2));
      repeat (3) send_item(make_tick());
      // An oversized target saturates; a ramp down replaces the running ramp.
      send_item(make_start(MODE_UP_ONLY, 1'b1, 1'b0, 7'd127, 16'hFFFF));
      repeat (2) send_item(make_tick());
      send_item(make_start(MODE_DOWN, 1'b0, 1'b1, 7'd100, 16'd0));
      repeat (3) send_item(make_tick());
      // The unused mode is ignored.
      send_item(make_start(MODE_UNUSED, 1'b0, 1'b0, 7'd50, 16'd0));
      // A long hold cut short by a new start.
      send_item(make_start(MODE_PULSE, 1'b0, 1'b0, 7'd1, 16'hFFFF));
      send_item(make_tick());
      send_item(make_start(MODE_UP_ONLY, 1'b1, 1'b1, 7'd1, 16'd0));
      send_item(make_tick());
      req_if.valid <= 1'b0;

      // Random phases, each under its own register setting.
      for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
         drain_results();
         steady = (ph % 4 == 0);
         case (ph)
            1: program_registers(8'd255, 1'b0, 7'd100, 7'd0, 8'd0);
            2: program_registers(8'd0, 1'b1, 7'd0, 7'd100, 8'd2);
            3: program_registers(8'd255, 1'b1, 7'd127, 7'd127, 8'd1);
            4: program_registers(8'($urandom), 1'($urandom), 7'($urandom_range(0, 100)),
                                 7'($urandom_range(0, 100)), 8'd255);
            5: program_registers(8'd1, 1'b1, 7'd0, 7'd0, 8'd1);
            default: program_registers(8'($urandom), 1'($urandom),
                                       7'($urandom_range(0, 100)),
                                       7'($urandom_range(0, 100)),
                                       8'($urandom_range(0, 3)));
         endcase
         run_random(PHASE_ITEMS);
      end

      drain_results();
      if (sb.pending() != 0) begin
         sb.report_mismatch("expected results never arrived", 16'(sb.pending()), 16'd0);
      end
      $display("Sent %0d items under %0d register settings; %0d results compared.",
               items_sent, settings_used + 1, sb.checked);
      $display("Ramps, pulses, holds, brake mode and a %0d-cycle stall covered; %0d mismatches.",
               STALL_CYCLES, sb.errors);
      if (sb.errors == 0) begin
         $display("dual_motor_ramp_pwm_sequencer_core test passed");
      end else begin
         $display("dual_motor_ramp_pwm_sequencer_core test failed");
      end
      $finish;
   end

endmodule

// ===== dual_motor_ramp_pwm_sequencer_core.f =====
src/dmrp_pkg.sv
src/dmrp_if.sv
src/dual_motor_ramp_pwm_sequencer_core.sv
tb/sv/dual_motor_ramp_pwm_sequencer_core_tb.sv
